### hw/rtl/iwms_pkg.sv
// Shared types and constants for the interval window merge and sum block.
`default_nettype none

package iwms_pkg;

  localparam int unsigned NUM_COLUMNS = 4;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned SumW        = 48;
  localparam int unsigned WinCfgW     = 7;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned InDataW     = 2 * CoordW + NUM_COLUMNS * ValueW;
  localparam int unsigned OutDataW    = 2 * CoordW + NUM_COLUMNS * SumW;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrW    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW    = $clog2(FifoDepth + 3);

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_MAX_GAP     = 2'd1
  } cfg_reg_e;

  typedef logic [NUM_COLUMNS-1:0][ValueW-1:0] col_values_t;
  typedef logic [NUM_COLUMNS-1:0][SumW-1:0]   col_sums_t;

  // One entry of the head memory: interval start and gap prefix sum.
  typedef struct packed {
    logic [CoordW-1:0] start_pos;
    logic [SumW-1:0]   gsum;
  } iwms_head_t;

  // Item state after the accept stage, waiting for the memory read data.
  typedef struct packed {
    logic              emit;
    logic              base_zero;
    logic              single;
    logic [CoordW-1:0] start_pos;
    logic [CoordW-1:0] end_pos;
    col_sums_t         psum;
    logic [SumW-1:0]   gsum;
  } iwms_item_t;

  // Result layout equals the output tdata layout (start in the lowest bits).
  typedef struct packed {
    col_sums_t         sums;
    logic [CoordW-1:0] end_pos;
    logic [CoordW-1:0] start_pos;
  } iwms_result_t;

endpackage

`default_nettype wire

### hw/rtl/iwms_line_mem.sv
// Delay line memories: column prefix sums and interval start with gap prefix sum.
`default_nettype none

module iwms_line_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [AW-1:0]       wr_addr_i,
  input  wire iwms_pkg::col_sums_t wr_psum_i,
  input  wire iwms_pkg::iwms_head_t wr_head_i,
  input  wire logic                rd_en_i,
  input  wire logic [AW-1:0]       rd_psum_addr_i,
  input  wire logic [AW-1:0]       rd_head_addr_i,
  output iwms_pkg::col_sums_t      rd_psum_o,
  output iwms_pkg::iwms_head_t     rd_head_o
);
  import iwms_pkg::*;

  col_sums_t  psum_mem [DEPTH];
  iwms_head_t head_mem [DEPTH];
  col_sums_t  rd_psum_q;
  iwms_head_t rd_head_q;

  // Reads see the old contents when they hit the entry written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      psum_mem[wr_addr_i] <= wr_psum_i;
    end
    if (rd_en_i) begin
      rd_psum_q <= psum_mem[rd_psum_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      head_mem[wr_addr_i] <= wr_head_i;
    end
    if (rd_en_i) begin
      rd_head_q <= head_mem[rd_head_addr_i];
    end
  end

  assign rd_psum_o = rd_psum_q;
  assign rd_head_o = rd_head_q;

endmodule

`default_nettype wire

### hw/rtl/iwms_prefix.sv
// Accept stage: running prefix sums, fill counter, ring pointer and read addresses.
`default_nettype none

module iwms_prefix #(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned AW         = 6,
  parameter int unsigned CW         = 7
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic                  new_set_i,
  input  wire logic [iwms_pkg::CoordW-1:0] start_i,
  input  wire logic [iwms_pkg::CoordW-1:0] end_i,
  input  wire iwms_pkg::col_values_t values_i,
  input  wire logic [CW-1:0]         weff_i,
  output logic [AW-1:0]              wr_addr_o,
  output iwms_pkg::col_sums_t        wr_psum_o,
  output iwms_pkg::iwms_head_t       wr_head_o,
  output logic [AW-1:0]              rd_psum_addr_o,
  output logic [AW-1:0]              rd_head_addr_o,
  output logic                       valid_o,
  output iwms_pkg::iwms_item_t       item_o
);
  import iwms_pkg::*;

  logic [AW-1:0]     wp_q, wp_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  col_sums_t         psum_q, psum_d;
  logic [SumW-1:0]   gsum_q, gsum_d;
  logic [SumW-1:0]   gap_step;
  logic [CoordW-1:0] prev_end_q;
  logic              first;
  logic              valid_q;
  iwms_item_t        item_q, item_d;

  // Slot that lies 'back' places behind the slot being written (back <= WINDOW_MAX).
  function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] slot,
                                              input logic [CW-1:0] back);
    logic [AW:0] tmp;
    tmp = {1'b0, slot} + (AW+1)'(WINDOW_MAX) - (AW+1)'(back);
    if (tmp >= (AW+1)'(WINDOW_MAX)) begin
      tmp = tmp - (AW+1)'(WINDOW_MAX);
    end
    return tmp[AW-1:0];
  endfunction

  assign first    = new_set_i || (cnt_q == '0);
  assign gap_step = {{(SumW-CoordW){1'b0}}, start_i} - {{(SumW-CoordW){1'b0}}, prev_end_q}
                  - SumW'(1);

  always_comb begin
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      psum_d[c] = (first ? '0 : psum_q[c])
                + {{(SumW-ValueW){values_i[c][ValueW-1]}}, values_i[c]};
    end
    gsum_d = first ? '0 : (gsum_q + gap_step);
    if (first) begin
      cnt_d = CW'(1);
    end else if (cnt_q == CW'(WINDOW_MAX + 1)) begin
      cnt_d = cnt_q;
    end else begin
      cnt_d = cnt_q + CW'(1);
    end
    wp_d = (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : (wp_q + AW'(1));

    item_d.emit      = (cnt_d >= weff_i);
    item_d.base_zero = (cnt_d == weff_i);
    item_d.single    = (weff_i == CW'(1));
    item_d.start_pos = start_i;
    item_d.end_pos   = end_i;
    item_d.psum      = psum_d;
    item_d.gsum      = gsum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
      if (accept_i) begin
        wp_q  <= wp_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      psum_q     <= psum_d;
      gsum_q     <= gsum_d;
      prev_end_q <= end_i;
      item_q     <= item_d;
    end
  end

  assign wr_addr_o           = wp_q;
  assign wr_psum_o           = psum_d;
  assign wr_head_o.start_pos = start_i;
  assign wr_head_o.gsum      = gsum_d;
  assign rd_psum_addr_o      = slot_back(wp_q, weff_i);
  assign rd_head_addr_o      = slot_back(wp_q, weff_i - CW'(1));
  assign valid_o             = valid_q;
  assign item_o              = item_q;

endmodule

`default_nettype wire

### hw/rtl/iwms_window.sv
// Window stage: prefix differences, then the gap threshold test.
`default_nettype none

module iwms_window (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire iwms_pkg::iwms_item_t item_i,
  input  wire iwms_pkg::col_sums_t  rd_psum_i,
  input  wire iwms_pkg::iwms_head_t rd_head_i,
  input  wire logic [iwms_pkg::CoordW-1:0] max_gap_i,
  output logic                      valid_o,
  output logic                      push_o,
  output iwms_pkg::iwms_result_t    result_o
);
  import iwms_pkg::*;

  logic            valid_q;
  logic            emit_q;
  logic [SumW-1:0] gap_q, gap_d;
  iwms_result_t    res_q, res_d;
  logic [SumW-1:0] limit;

  always_comb begin
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      res_d.sums[c] = item_i.psum[c] - (item_i.base_zero ? '0 : rd_psum_i[c]);
    end
    // A one-interval window has no gap and the head entry is this interval.
    res_d.start_pos = item_i.single ? item_i.start_pos : rd_head_i.start_pos;
    res_d.end_pos   = item_i.end_pos;
    gap_d           = item_i.single ? '0 : (item_i.gsum - rd_head_i.gsum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      emit_q <= item_i.emit;
      gap_q  <= gap_d;
      res_q  <= res_d;
    end
  end

  assign limit    = {{(SumW-CoordW){max_gap_i[CoordW-1]}}, max_gap_i};
  assign valid_o  = valid_q;
  assign push_o   = valid_q && emit_q && ($signed(gap_q) < $signed(limit));
  assign result_o = res_q;

endmodule

`default_nettype wire

### hw/rtl/iwms_out_fifo.sv
// Small result queue that separates the output handshake from the pipeline.
`default_nettype none

module iwms_out_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire iwms_pkg::iwms_result_t data_i,
  input  wire logic                   pop_i,
  output logic                        valid_o,
  output iwms_pkg::iwms_result_t      data_o,
  output logic [iwms_pkg::FifoCntW-1:0] count_o
);
  import iwms_pkg::*;

  iwms_result_t        store_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + FifoCntW'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - FifoCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = store_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

`default_nettype wire

### hw/rtl/interval_window_merge_sum.sv
// Top level of the interval window merge and sum block.
//
//  Channel   Direction  Transaction carries
//  s_axis    in         one sorted interval: tuser = new_set, tdata = start, end, four values
//  m_axis    out        one merged window: start, end and four column sums
//  cfg       in         one register write: window_size (index 0), max_gap (index 1)
//
// One interval is accepted per cycle while s_axis_tready is high. A result, if any, passes
// the accept stage (memory read issued), the difference stage and the threshold stage into
// a four-entry queue. s_axis_tready drops only when the queue plus the two items in
// flight could fill it, so stalls on m_axis never drop or repeat a result.
// Reset clears the fill counter, ring pointer, queue and pipeline valid bits; memory
// contents need no clearing because the fill counter masks every stale entry.
`default_nettype none

module interval_window_merge_sum #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input intervals.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata from bit 0: interval_start, interval_end, value_a, value_b, value_c, value_d
  input  wire logic [iwms_pkg::InDataW-1:0]    s_axis_tdata,
  // tuser from bit 0: new_set
  input  wire logic                            s_axis_tuser,
  // Merged windows.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // tdata from bit 0: merged_start, merged_end, sum_a, sum_b, sum_c, sum_d
  output logic [iwms_pkg::OutDataW-1:0]        m_axis_tdata,
  // Register writes.
  input  wire logic                            cfg_we_i,
  input  wire logic [iwms_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [iwms_pkg::CfgDataW-1:0]   cfg_data_i
);
  import iwms_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_MAX);
  localparam int unsigned CW = $clog2(WINDOW_MAX + 2);

  // Configuration: the window size is stored already clamped to 1..WINDOW_MAX.
  logic [CW-1:0]     weff_q, weff_d;
  logic [CoordW-1:0] max_gap_q;
  logic [31:0]       ws_ext;

  logic              accept;
  col_values_t       in_values;
  logic [AW-1:0]     wr_addr, rd_psum_addr, rd_head_addr;
  col_sums_t         wr_psum, rd_psum;
  iwms_head_t        wr_head, rd_head;
  logic              s1_valid, s2_valid, push;
  iwms_item_t        s1_item;
  iwms_result_t      result, fifo_data;
  logic [FifoCntW-1:0] fifo_cnt, outstanding;

  assign ws_ext = 32'(cfg_data_i[WinCfgW-1:0]);

  always_comb begin
    if (ws_ext == 32'd0) begin
      weff_d = CW'(1);
    end else if (ws_ext > 32'(WINDOW_MAX)) begin
      weff_d = CW'(WINDOW_MAX);
    end else begin
      weff_d = CW'(ws_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weff_q    <= CW'(1);
      max_gap_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_SIZE: weff_q    <= weff_d;
        REG_MAX_GAP:     max_gap_q <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // Credit check: every item in flight may still need a queue slot.
  assign outstanding   = fifo_cnt + FifoCntW'(s1_valid) + FifoCntW'(s2_valid);
  assign s_axis_tready = (outstanding < FifoCntW'(FifoDepth));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int c = 0; c < NUM_COLUMNS; c++) begin
      in_values[c] = s_axis_tdata[2*CoordW + c*ValueW +: ValueW];
    end
  end

  iwms_prefix #(
    .WINDOW_MAX (WINDOW_MAX),
    .AW         (AW),
    .CW         (CW)
  ) u_prefix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .new_set_i      (s_axis_tuser),
    .start_i        (s_axis_tdata[CoordW-1:0]),
    .end_i          (s_axis_tdata[2*CoordW-1:CoordW]),
    .values_i       (in_values),
    .weff_i         (weff_q),
    .wr_addr_o      (wr_addr),
    .wr_psum_o      (wr_psum),
    .wr_head_o      (wr_head),
    .rd_psum_addr_o (rd_psum_addr),
    .rd_head_addr_o (rd_head_addr),
    .valid_o        (s1_valid),
    .item_o         (s1_item)
  );

  iwms_line_mem #(
    .DEPTH (WINDOW_MAX),
    .AW    (AW)
  ) u_line_mem (
    .clk_i          (clk_i),
    .wr_en_i        (accept),
    .wr_addr_i      (wr_addr),
    .wr_psum_i      (wr_psum),
    .wr_head_i      (wr_head),
    .rd_en_i        (accept),
    .rd_psum_addr_i (rd_psum_addr),
    .rd_head_addr_i (rd_head_addr),
    .rd_psum_o      (rd_psum),
    .rd_head_o      (rd_head)
  );

  iwms_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .item_i    (s1_item),
    .rd_psum_i (rd_psum),
    .rd_head_i (rd_head),
    .max_gap_i (max_gap_q),
    .valid_o   (s2_valid),
    .push_o    (push),
    .result_o  (result)
  );

  iwms_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (fifo_data),
    .count_o (fifo_cnt)
  );

  assign m_axis_tdata = fifo_data;

  // The credit scheme must never let outstanding items exceed the queue depth.
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding <= FifoCntW'(FifoDepth))
    else $error("outstanding items exceed result queue depth");

  // A pushed result must always find room in the queue.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt < FifoCntW'(FifoDepth)))
    else $error("result pushed into a full queue");

  // The stored window size stays within the legal range.
  a_weff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (weff_q != '0) && (weff_q <= CW'(WINDOW_MAX)))
    else $error("effective window size out of range");

endmodule

`default_nettype wire
